[rtl/core/ecws_pkg.sv]
`default_nettype none

package ecws_pkg;

    // Number of waiter slots; the link entries and the link address width follow from it.
    localparam int WAITERS     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int LINK_AW     = $clog2(WAITERS);

    localparam int OP_W  = 3;
    localparam int ID_W  = 4;
    localparam int CNT_W = 5;
    localparam int K_W   = $clog2(MAX_RESULTS);

    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [CNT_W-1:0] EMPTY_TOP = 5'd31;
    localparam logic [CNT_W-1:0] WAITERS_C = CNT_W'(WAITERS);

    localparam logic [OP_W-1:0] OP_PREPARE    = 3'd0;
    localparam logic [OP_W-1:0] OP_COMMIT     = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL     = 3'd2;
    localparam logic [OP_W-1:0] OP_NOTIFY_ONE = 3'd3;
    localparam logic [OP_W-1:0] OP_NOTIFY_ALL = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } t_state;

endpackage

`default_nettype wire

[rtl/core/event_count_waiter_stack_core.sv]
//  channel | valid      | ready      | payload
//  --------+------------+------------+---------------------------------------------
//  in      | i_in_valid | o_in_ready | i_opcode, i_waiter_id
//  out     | o_out_valid| i_out_ready| o_wake_valid, o_wake_id, o_immediate,
//          |            |            | o_op_error, o_last
//
//  One item is handled at a time. Prepare, commit, cancel and notify-one pass
//  through accept and execute. Notify-all with parked waiters adds a walk that
//  follows one next-link per cycle, when the output does not stall, through the
//  single read port of the link memory. Output stalls hold the sequencer in place.
//  Synchronous active-low reset clears counters and empties the stack; the
//  link memory is not cleared (every entry is written when its id is pushed).
`default_nettype none

module event_count_waiter_stack_core
    import ecws_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [ID_W-1:0]   i_waiter_id,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_wake_valid,
    output logic [ID_W-1:0]        o_wake_id,
    output logic                   o_immediate,
    output logic                   o_op_error,
    output logic                   o_last
);

    // Sequencer and latched item
    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_id;

    // Architectural state
    logic [CNT_W-1:0]   r_prewait, n_prewait;
    logic [CNT_W-1:0]   r_signal,  n_signal;
    logic [CNT_W-1:0]   r_top,     n_top;

    // Walk pointer and result count for notify-all
    logic [CNT_W-1:0]   r_cur, n_cur;
    logic [K_W-1:0]     r_k,   n_k;

    // Next-link memory: one write port, one registered read port
    logic [CNT_W-1:0]   r_link_mem [WAITERS];
    logic [CNT_W-1:0]   r_rd_data;
    logic [LINK_AW-1:0] rd_addr;
    logic               mem_we;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic               r_wake_valid, n_wake_valid;
    logic [ID_W-1:0]    r_wake_id, n_wake_id;
    logic               r_immediate, n_immediate;
    logic               r_op_error, n_op_error;
    logic               r_last, n_last;

    logic               slot_free;
    logic               emit;
    logic               go_walk;
    logic               walk_end;
    logic               empty;
    logic               counts_eq;
    logic               id_ok;

    assign slot_free = !r_out_valid || i_out_ready;
    assign empty     = !(r_top < WAITERS_C);
    assign counts_eq = (r_prewait == r_signal);
    assign id_ok     = ({1'b0, r_id} < WAITERS_C);
    // walk stops at the empty mark or after the result cap (loops from re-push)
    assign walk_end  = (r_k == K_W'(MAX_RESULTS - 1)) || !(r_rd_data < WAITERS_C);

    assign o_in_ready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (go_walk) n_state = ST_WALK;
                else if (slot_free) n_state = ST_IDLE;
            end
            ST_WALK: begin
                if (slot_free && walk_end) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_prewait    = r_prewait;
        n_signal     = r_signal;
        n_top        = r_top;
        n_cur        = r_cur;
        n_k          = r_k;
        mem_we       = 1'b0;
        emit         = 1'b0;
        go_walk      = 1'b0;
        n_wake_valid = 1'b0;
        n_wake_id    = '0;
        n_immediate  = 1'b0;
        n_op_error   = 1'b0;
        n_last       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_EXEC: begin
                if (r_op == OP_NOTIFY_ALL && !empty) begin
                    // equalize counts, empty the stack, walk from the old top
                    go_walk  = 1'b1;
                    n_signal = r_prewait;
                    n_top    = EMPTY_TOP;
                    n_cur    = r_top;
                    n_k      = '0;
                end else if (slot_free) begin
                    emit = 1'b1;
                    unique case (r_op)
                        OP_PREPARE: begin
                            if (r_prewait == COUNT_MAX) n_op_error = 1'b1;
                            else n_prewait = r_prewait + 1'b1;
                        end
                        OP_COMMIT: begin
                            if (r_prewait == '0 || !id_ok) begin
                                n_op_error = 1'b1;
                            end else if (r_signal != '0) begin
                                n_prewait   = r_prewait - 1'b1;
                                n_signal    = r_signal - 1'b1;
                                n_immediate = 1'b1;
                            end else begin
                                // park: link to old top, push
                                n_prewait = r_prewait - 1'b1;
                                mem_we    = 1'b1;
                                n_top     = {1'b0, r_id};
                            end
                        end
                        OP_CANCEL: begin
                            if (r_prewait == '0) begin
                                n_op_error = 1'b1;
                            end else begin
                                if (counts_eq) n_signal = r_signal - 1'b1;
                                n_prewait = r_prewait - 1'b1;
                            end
                        end
                        OP_NOTIFY_ONE: begin
                            priority if (empty && counts_eq) begin
                            end else if (r_signal < r_prewait) begin
                                n_signal = r_signal + 1'b1;
                            end else if (empty) begin
                            end else begin
                                // pop; link of the top was read at accept
                                n_top        = r_rd_data;
                                n_wake_valid = 1'b1;
                                n_wake_id    = r_top[ID_W-1:0];
                            end
                        end
                        OP_NOTIFY_ALL: begin
                            // empty stack: equalize only
                            n_signal = r_prewait;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (slot_free) begin
                    emit         = 1'b1;
                    n_wake_valid = 1'b1;
                    n_wake_id    = r_cur[ID_W-1:0];
                    n_last       = walk_end;
                    n_cur        = r_rd_data;
                    n_k          = r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // read address: top of stack, or the walk pointer (advanced when a result leaves)
    always_comb begin
        if (r_state == ST_WALK) begin
            rd_addr = slot_free ? r_rd_data[LINK_AW-1:0] : r_cur[LINK_AW-1:0];
        end else begin
            rd_addr = r_top[LINK_AW-1:0];
        end
    end

    assign n_out_valid = emit ? 1'b1 : (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[r_id[LINK_AW-1:0]] <= r_top;
        end
        r_rd_data <= r_link_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prewait   <= '0;
            r_signal    <= '0;
            r_top       <= EMPTY_TOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prewait   <= n_prewait;
            r_signal    <= n_signal;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op <= i_opcode;
            r_id <= i_waiter_id;
        end
        r_cur <= n_cur;
        r_k   <= n_k;
        if (emit) begin
            r_wake_valid <= n_wake_valid;
            r_wake_id    <= n_wake_id;
            r_immediate  <= n_immediate;
            r_op_error   <= n_op_error;
            r_last       <= n_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_wake_valid = r_wake_valid;
    assign o_wake_id    = r_wake_id;
    assign o_immediate  = r_immediate;
    assign o_op_error   = r_op_error;
    assign o_last       = r_last;

endmodule

`default_nettype wire

[rtl/core/ecws_checker.sv]
`default_nettype none

module ecws_checker
    import ecws_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire logic            o_wake_valid,
    input wire logic [ID_W-1:0] o_wake_id,
    input wire logic            o_immediate,
    input wire logic            o_op_error,
    input wire logic            o_last
);

    // an error result names no waiter and closes its item
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_op_error |-> !o_wake_valid && !o_immediate && o_last)
        else $error("error result carries other flags");

    // immediate commit never wakes anyone and is a single result
    a_imm_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_immediate |-> !o_wake_valid && o_last)
        else $error("immediate result malformed");

    // mid-stream of a notify-all walk no new item is taken
    a_no_accept_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input accepted during wake stream");

    // no wake means a zero id
    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_wake_valid |-> o_wake_id == '0)
        else $error("wake id set without wake");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_wake_id)
            && $stable(o_last) && $stable(o_wake_valid))
        else $error("stalled result changed");

endmodule

bind event_count_waiter_stack_core ecws_checker u_ecws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_wake_valid (o_wake_valid),
    .o_wake_id    (o_wake_id),
    .o_immediate  (o_immediate),
    .o_op_error   (o_op_error),
    .o_last       (o_last)
);

`default_nettype wire

[dv/event_count_waiter_stack_core_test.sv]
`timescale 1ns / 1ps

module event_count_waiter_stack_core_test;
    import ecws_pkg::*;

    // Opcodes outside the defined set; the block must let them pass untouched.
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 285;
    localparam int CALM_TAIL    = 40;       // items at the end sent with no idling
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;       // longer than a full notify-all walk, plus margin

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] waiter_id;
    } t_op_item;

    typedef struct packed {
        logic            wake_valid;
        logic [ID_W-1:0] wake_id;
        logic            immediate;
        logic            op_error;
        logic            last;
    } t_wake;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic [OP_W-1:0] i_opcode    = '0;
    logic [ID_W-1:0] i_waiter_id = '0;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    logic            o_wake_valid;
    logic [ID_W-1:0] o_wake_id;
    logic            o_immediate;
    logic            o_op_error;
    logic            o_last;

    event_count_waiter_stack_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_waiter_id  (i_waiter_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_wake_valid (o_wake_valid),
        .o_wake_id    (o_wake_id),
        .o_immediate  (o_immediate),
        .o_op_error   (o_op_error),
        .o_last       (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the unit's state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] pre_waiters     = '0;
    logic [CNT_W-1:0] pending_signals = '0;
    logic [CNT_W-1:0] parked_top      = EMPTY_TOP;
    logic [CNT_W-1:0] park_link [WAITERS];

    t_op_item pending_items[$];
    t_wake    expected_wakes[$];

    int total_items    = 0;
    int accepted_items = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int wakes_seen     = 0;
    int immediates     = 0;
    int flagged        = 0;
    int cycle_count    = 0;

    // Idle rates are re-rolled now and then so some stretches run flat out.
    int  gap_pct   = 0;
    int  stall_pct = 0;
    logic calm     = 1'b0;

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Works out the result items of one accepted item and updates the shadow.
    function automatic void predict_wakes(t_op_item it);
        t_wake            r;
        logic [CNT_W-1:0] cur;
        logic             empty;
        int               n;
        r      = '0;
        r.last = 1'b1;
        empty  = (parked_top >= WAITERS_C);
        case (it.opcode)
            OP_PREPARE: begin
                if (pre_waiters >= COUNT_MAX) r.op_error = 1'b1;
                else pre_waiters++;
            end
            OP_COMMIT: begin
                if (pre_waiters == 0 || {1'b0, it.waiter_id} >= WAITERS_C) begin
                    r.op_error = 1'b1;
                end else if (pending_signals != 0) begin
                    // a signal is already waiting: consume it, no park
                    pre_waiters--;
                    pending_signals--;
                    r.immediate = 1'b1;
                end else begin
                    pre_waiters--;
                    park_link[it.waiter_id] = parked_top;
                    parked_top = {1'b0, it.waiter_id};
                end
            end
            OP_CANCEL: begin
                if (pre_waiters == 0) begin
                    r.op_error = 1'b1;
                end else begin
                    // a signal earmarked for this waiter goes away with it
                    if (pre_waiters == pending_signals) pending_signals--;
                    pre_waiters--;
                end
            end
            OP_NOTIFY_ONE: begin
                if (empty && pre_waiters == pending_signals) begin
                    // nothing to notify
                end else if (pending_signals < pre_waiters) begin
                    pending_signals++;
                end else if (!empty) begin
                    r.wake_valid = 1'b1;
                    r.wake_id    = parked_top[ID_W-1:0];
                    parked_top   = park_link[parked_top[ID_W-1:0]];
                end
            end
            OP_NOTIFY_ALL: begin
                if (!(empty && pre_waiters == pending_signals)) begin
                    pending_signals = pre_waiters;
                    cur        = parked_top;
                    parked_top = EMPTY_TOP;
                    if (!empty) begin
                        // walk top-down; a looped stack is cut at MAX_RESULTS
                        n = 0;
                        while (n < MAX_RESULTS && cur < WAITERS_C) begin
                            r            = '0;
                            r.wake_valid = 1'b1;
                            r.wake_id    = cur[ID_W-1:0];
                            r.last       = (n == MAX_RESULTS - 1) ||
                                           (park_link[cur[ID_W-1:0]] >= WAITERS_C);
                            expected_wakes.push_back(r);
                            cur = park_link[cur[ID_W-1:0]];
                            n++;
                        end
                        return;
                    end
                end
            end
            default: ;  // reserved opcodes change nothing
        endcase
        expected_wakes.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds the input channel from pending_items
    // ------------------------------------------------------------------
    t_op_item current_item;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_wakes(current_item);
                accepted_items++;
            end
            // An item still waiting for ready keeps valid and payload as they are.
            if (!(i_in_valid && !o_in_ready)) begin
                if (gap_left == 0 && !calm && $urandom_range(0, 99) < gap_pct)
                    gap_left = $urandom_range(1, 18);
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    current_item = pending_items.pop_front();
                    i_in_valid  <= 1'b1;
                    i_opcode    <= current_item.opcode;
                    i_waiter_id <= current_item.waiter_id;
                end
            end
            calm <= (pending_items.size() < CALM_TAIL);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result items against the oldest expectation
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_wake want;
        logic  next_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_wake_valid) wakes_seen++;
                if (o_immediate) immediates++;
                if (o_op_error) flagged++;
                if (expected_wakes.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected (wake %0b id %0d)",
                                              o_wake_valid, o_wake_id));
                end else begin
                    want = expected_wakes.pop_front();
                    if (o_wake_valid !== want.wake_valid)
                        report_mismatch($sformatf("wake_valid got %0b want %0b",
                                                  o_wake_valid, want.wake_valid));
                    if (o_wake_id !== want.wake_id)
                        report_mismatch($sformatf("wake_id got %0d want %0d",
                                                  o_wake_id, want.wake_id));
                    if (o_immediate !== want.immediate)
                        report_mismatch($sformatf("immediate got %0b want %0b",
                                                  o_immediate, want.immediate));
                    if (o_op_error !== want.op_error)
                        report_mismatch($sformatf("op_error got %0b want %0b",
                                                  o_op_error, want.op_error));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  o_last, want.last));
                end
            end
            next_ready = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 18) - 1;
                next_ready = 1'b0;
            end
            i_out_ready <= next_ready;
        end
    end

    // Cycle counter, idle-rate shuffling and the run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 97 == 0) begin
            case ($urandom_range(0, 3))
                0: gap_pct <= 0;
                1: gap_pct <= 5;
                2: gap_pct <= 20;
                default: gap_pct <= 45;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 5;
                2: stall_pct <= 20;
                default: stall_pct <= 45;
            endcase
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout: %0d of %0d items accepted, %0d results outstanding",
                     accepted_items, total_items, expected_wakes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        t_op_item it;
        it.opcode    = op;
        it.waiter_id = id;
        pending_items.push_back(it);
        total_items++;
    endtask

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(0, WAITERS - 1));
    endfunction

    initial begin
        int              n;
        int              k;
        logic [ID_W-1:0] next_id;
        logic            flood_done;

        // --- directed part ---
        add_item(OP_NOTIFY_ONE, 4'd0);      // nothing to notify
        add_item(OP_NOTIFY_ALL, 4'd15);     // nothing to notify
        add_item(OP_CANCEL, 4'd3);          // cancel with no pre-waiter
        add_item(OP_COMMIT, 4'd15);         // commit with no pre-waiter
        add_item(OP_RSVD_5, 4'd10);
        add_item(OP_RSVD_7, 4'd5);
        // two parks: id 15 then id 0 on top
        add_item(OP_PREPARE, 4'd0);
        add_item(OP_PREPARE, 4'd0);
        add_item(OP_COMMIT, 4'd15);
        add_item(OP_COMMIT, 4'd0);
        // signal handed to a pre-waiter, then used by its commit
        add_item(OP_PREPARE, 4'd9);
        add_item(OP_NOTIFY_ONE, 4'd0);
        add_item(OP_COMMIT, 4'd9);
        add_item(OP_NOTIFY_ONE, 4'd0);      // pops id 0
        // cancel drops the earmarked signal when counts match
        add_item(OP_PREPARE, 4'd2);
        add_item(OP_NOTIFY_ONE, 4'd0);
        add_item(OP_CANCEL, 4'd2);
        add_item(OP_NOTIFY_ALL, 4'd0);      // walks the single id 15
        // same id pushed twice: self loop, walk cut at the result cap
        add_item(OP_PREPARE, 4'd0);
        add_item(OP_PREPARE, 4'd0);
        add_item(OP_COMMIT, 4'd5);
        add_item(OP_COMMIT, 4'd5);
        add_item(OP_NOTIFY_ALL, 4'd0);
        // notify-all on an empty stack with unequal counts
        add_item(OP_PREPARE, 4'd0);
        add_item(OP_NOTIFY_ALL, 4'd0);

        // --- random part ---
        next_id    = any_id();
        flood_done = 1'b0;
        while (total_items < 25 + RANDOM_ITEMS) begin
            k = $urandom_range(0, 9);
            if (k == 8 && flood_done) k = 0;
            if (!flood_done && total_items > 180) k = 8;
            if (k <= 5) begin
                // well-formed session: announce, then park or back out, then notify
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++) add_item(OP_PREPARE, any_id());
                if ($urandom_range(0, 3) == 0) add_item(OP_NOTIFY_ONE, any_id());
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_item(OP_CANCEL, any_id());
                    end else begin
                        add_item(OP_COMMIT, next_id);
                        next_id = next_id + ID_W'($urandom_range(1, 2));
                    end
                end
                if ($urandom_range(0, 2) == 0) begin
                    add_item(OP_NOTIFY_ALL, any_id());
                end else begin
                    n = $urandom_range(0, n + 1);
                    for (int j = 0; j < n; j++) add_item(OP_NOTIFY_ONE, any_id());
                end
            end else if (k == 6) begin
                // noise: any opcode, reserved ones included
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    add_item(OP_W'($urandom_range(0, 7)), any_id());
            end else if (k == 7) begin
                // broken sequences: commit / cancel / notify with no prepare
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++) begin
                    case ($urandom_range(0, 2))
                        0: add_item(OP_COMMIT, any_id());
                        1: add_item(OP_CANCEL, any_id());
                        default: add_item(OP_NOTIFY_ONE, any_id());
                    endcase
                end
            end else if (k == 8) begin
                // drive the pre-wait count past full, then drain it again
                for (int j = 0; j < int'(COUNT_MAX) + 2; j++) add_item(OP_PREPARE, any_id());
                add_item(OP_NOTIFY_ALL, any_id());
                for (int j = 0; j < int'(COUNT_MAX) + 2; j++) add_item(OP_CANCEL, any_id());
                flood_done = 1'b1;
            end else begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++) add_item(OP_NOTIFY_ONE, any_id());
                add_item(OP_NOTIFY_ALL, any_id());
            end
        end

        // reset: synchronous, held low from the start, released once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items < total_items) @(posedge i_clk);
        while (expected_wakes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_wakes.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_wakes.size()));

        $display("run: %0d items through prepare/commit/cancel/notify, %0d results checked",
                 accepted_items, results_seen);
        $display("     %0d wakes, %0d immediate commits, %0d flagged ops, %0d mismatches",
                 wakes_seen, immediates, flagged, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
